### rtl/psa_pkg.sv
// shared types and constants of the priority scheduler with aging
package psa_pkg;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W           = 1;
    localparam logic REG_AGING_THRESHOLD = 1'b0;
    localparam logic REG_PRIORITY_FLOOR  = 1'b1;

    // reset values and saturation limits
    localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
    localparam logic [7:0]  FLOOR_RESET     = 8'd1;
    localparam logic [7:0]  WAIT_MAX        = 8'hFF;
    localparam logic [15:0] AGING_MAX       = 16'hFFFF;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  slot;
        logic [15:0] burst;
        logic [7:0]  priority_req;
    } t_req;

    typedef struct packed {
        logic        granted_valid;
        logic [2:0]  granted_slot;
        logic        preempted;
        logic        first_start;
        logic [31:0] response_time;
        logic        finished;
        logic [31:0] finish_time;
        logic [15:0] aging_events;
    } t_res;

    // controls for the aging step of one slot
    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] floor;
        logic       skip;
    } t_age_ctl;

endpackage

### rtl/psa_ram.sv
// generic single write port ram with registered read
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/psa_age.sv
// aging step applied to one slot entry during the scan
module psa_age #(
    parameter int BURST_BITS = 16
) (
    input  logic [BURST_BITS+48:0] i_entry,
    input  psa_pkg::t_age_ctl      i_ctl,
    output logic [BURST_BITS+48:0] o_entry,
    output logic                   o_aged
);
    import psa_pkg::*;

    typedef struct packed {
        logic [BURST_BITS-1:0] rem;
        logic [7:0]            prio;
        logic [7:0]            wait_cnt;
        logic [31:0]           arrival;
        logic                  started;
    } t_entry;

    t_entry     w_in;
    t_entry     w_out;
    logic [7:0] w_wait;

    assign w_in = t_entry'(i_entry);

    always_comb begin
        w_out  = w_in;
        o_aged = 1'b0;
        w_wait = w_in.wait_cnt;
        if (w_in.rem != '0 && !i_ctl.skip) begin
            if (w_in.wait_cnt != WAIT_MAX) begin
                w_wait = w_in.wait_cnt + 8'd1;
            end
            // count reached threshold: lower priority value toward the floor
            if (w_wait >= i_ctl.threshold) begin
                if (w_in.prio > i_ctl.floor) begin
                    w_out.prio = w_in.prio - 8'd1;
                end
                o_aged = 1'b1;
                w_wait = 8'd0;
            end
            w_out.wait_cnt = w_wait;
        end
    end

    assign o_entry = w_out;
endmodule

### rtl/priority_scheduler_with_aging.sv
// top level of the preemptive priority scheduler with aging
// A load request writes one job slot while busy stays low, and the result
// strobe o_done follows in the next cycle. A tick request runs a scan over
// the slot table held in one synchronous ram, one slot per cycle: busy stays
// high while the ram reads, the aging step and the final grant write run, and
// o_done goes high in the same cycle that busy falls. A new request may be
// started in the cycle that o_done is high. Results cannot be held off by the
// receiver: each one is on o_result while o_done is high and stays there until
// the next result.
// Configuration writes are always taken (o_cfg_ready is tied high) and should
// only be issued while the block is idle. Slot entries reset to empty through
// a valid bit per slot, so no clearing pass is needed after reset.
module priority_scheduler_with_aging #(
    parameter int NUM_SLOTS  = 8,
    parameter int BURST_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  psa_pkg::t_req                  i_req,
    // result channel
    output logic                           o_done,
    output psa_pkg::t_res                  o_result,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import psa_pkg::*;

    localparam int IDXW    = $clog2(NUM_SLOTS);
    localparam int CNTW    = $clog2(NUM_SLOTS + 1);
    localparam int ENTRY_W = BURST_BITS + 49;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // one ram word per slot
    typedef struct packed {
        logic [BURST_BITS-1:0] rem;
        logic [7:0]            prio;
        logic [7:0]            wait_cnt;
        logic [31:0]           arrival;
        logic                  started;
    } t_entry;

    // control state
    logic                  r_state,    n_state;
    logic [CNTW-1:0]       r_cnt,      n_cnt;
    logic                  r_pv,       n_pv;
    logic [IDXW-1:0]       r_pidx,     n_pidx;
    logic                  r_rd_vld,   n_rd_vld;
    logic [NUM_SLOTS-1:0]  r_vld,      n_vld;
    logic [7:0]            r_thr,      n_thr;
    logic [7:0]            r_floor,    n_floor;
    logic [31:0]           r_time,     n_time;
    logic                  r_lr_valid, n_lr_valid;
    logic [IDXW-1:0]       r_lr_slot,  n_lr_slot;
    logic [15:0]           r_aging,    n_aging;
    logic                  r_found,    n_found;
    logic                  r_done,     n_done;
    // payload
    logic [IDXW-1:0]       r_best,     n_best;
    t_entry                r_best_ent, n_best_ent;
    t_res                  r_res,      n_res;

    // ram port
    logic                  w_we;
    logic [IDXW-1:0]       w_waddr;
    t_entry                w_wdata;
    logic                  w_re;
    logic [IDXW-1:0]       w_raddr;
    logic [ENTRY_W-1:0]    w_rdata;

    logic                  w_accept;
    logic                  w_scan_end;
    logic [31:0]           w_slot_wide;
    logic                  w_load_ok;
    logic [IDXW-1:0]       w_load_idx;
    logic [31:0]           w_burst_wide;
    logic [31:0]           w_best_wide;
    t_entry                w_rd_ent;
    t_age_ctl              w_age_ctl;
    logic [ENTRY_W-1:0]    w_age_out_vec;
    t_entry                w_age_out;
    logic                  w_aged;
    t_entry                w_grant_ent;

    psa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // slot never written since reset reads as empty
    assign w_rd_ent = r_rd_vld ? t_entry'(w_rdata) : '0;

    // the job that ran on the previous tick does not age
    assign w_age_ctl.threshold = r_thr;
    assign w_age_ctl.floor     = r_floor;
    assign w_age_ctl.skip      = r_lr_valid && (r_lr_slot == r_pidx);

    psa_age #(
        .BURST_BITS (BURST_BITS)
    ) u_age (
        .i_entry (w_rd_ent),
        .i_ctl   (w_age_ctl),
        .o_entry (w_age_out_vec),
        .o_aged  (w_aged)
    );

    assign w_age_out = t_entry'(w_age_out_vec);

    assign busy        = (r_state == ST_SCAN);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // load decode: slots beyond the table are ignored, burst masked to width
    assign w_slot_wide  = 32'(i_req.slot);
    assign w_load_ok    = (w_slot_wide < NUM_SLOTS);
    assign w_load_idx   = w_slot_wide[IDXW-1:0];
    assign w_burst_wide = 32'(i_req.burst);

    // scan is over once every slot was read and the last one processed
    assign w_scan_end  = (r_cnt == CNTW'(NUM_SLOTS)) && !r_pv;
    assign w_best_wide = 32'(r_best);

    // granted job: one unit of work done, marked as started
    always_comb begin
        w_grant_ent         = r_best_ent;
        w_grant_ent.rem     = r_best_ent.rem - BURST_BITS'(1);
        w_grant_ent.started = 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_rd_vld   = r_rd_vld;
        n_vld      = r_vld;
        n_thr      = r_thr;
        n_floor    = r_floor;
        n_time     = r_time;
        n_lr_valid = r_lr_valid;
        n_lr_slot  = r_lr_slot;
        n_aging    = r_aging;
        n_found    = r_found;
        n_done     = 1'b0;
        n_best     = r_best;
        n_best_ent = r_best_ent;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = r_pidx;
        w_wdata    = w_age_out;
        w_re       = 1'b0;
        w_raddr    = r_cnt[IDXW-1:0];

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AGING_THRESHOLD: n_thr   = i_cfg_data;
                REG_PRIORITY_FLOOR:  n_floor = i_cfg_data;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_LOAD) begin
                        if (w_load_ok) begin
                            w_we             = 1'b1;
                            w_waddr          = w_load_idx;
                            w_wdata.rem      = w_burst_wide[BURST_BITS-1:0];
                            w_wdata.prio     = i_req.priority_req;
                            w_wdata.wait_cnt = 8'd0;
                            w_wdata.arrival  = r_time;
                            w_wdata.started  = 1'b0;
                            // reloaded slot has not run yet
                            if (r_lr_valid && (r_lr_slot == w_load_idx)) begin
                                n_lr_valid = 1'b0;
                            end
                        end
                        n_done               = 1'b1;
                        n_res                = '0;
                        n_res.aging_events   = r_aging;
                    end else begin
                        n_state = ST_SCAN;
                        n_cnt   = '0;
                        n_found = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // read side: one slot per cycle
                if (r_cnt != CNTW'(NUM_SLOTS)) begin
                    w_re     = 1'b1;
                    n_cnt    = r_cnt + CNTW'(1);
                    n_pv     = 1'b1;
                    n_pidx   = r_cnt[IDXW-1:0];
                    n_rd_vld = r_vld[r_cnt[IDXW-1:0]];
                end
                // process side: age the slot read last cycle, track the best
                if (r_pv) begin
                    w_we            = 1'b1;
                    w_waddr         = r_pidx;
                    w_wdata         = w_age_out;
                    n_vld[r_pidx]   = 1'b1;
                    if (w_aged && (r_aging != AGING_MAX)) begin
                        n_aging = r_aging + 16'd1;
                    end
                    // strict compare keeps ties on the lowest slot
                    if (w_age_out.rem != '0
                        && (!r_found || (w_age_out.prio < r_best_ent.prio))) begin
                        n_found    = 1'b1;
                        n_best     = r_pidx;
                        n_best_ent = w_age_out;
                    end
                end
                // grant and write back the chosen slot
                if (w_scan_end) begin
                    n_state            = ST_IDLE;
                    n_done             = 1'b1;
                    n_res              = '0;
                    n_res.aging_events = r_aging;
                    n_time             = r_time + 32'd1;
                    if (r_found) begin
                        w_we                = 1'b1;
                        w_waddr             = r_best;
                        w_wdata             = w_grant_ent;
                        n_res.granted_valid = 1'b1;
                        n_res.granted_slot  = w_best_wide[2:0];
                        n_res.preempted     = r_lr_valid && (r_lr_slot != r_best);
                        if (!r_best_ent.started) begin
                            n_res.first_start   = 1'b1;
                            n_res.response_time = r_time - r_best_ent.arrival;
                        end
                        if (w_grant_ent.rem == '0) begin
                            n_res.finished    = 1'b1;
                            n_res.finish_time = r_time + 32'd1;
                        end
                        n_lr_valid = 1'b1;
                        n_lr_slot  = r_best;
                    end
                end
            end
        endcase

        // a load marks its slot as written
        if (w_accept && (i_req.req_type == REQ_LOAD) && w_load_ok) begin
            n_vld[w_load_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_pidx     <= '0;
            r_rd_vld   <= 1'b0;
            r_vld      <= '0;
            r_thr      <= THRESHOLD_RESET;
            r_floor    <= FLOOR_RESET;
            r_time     <= '0;
            r_lr_valid <= 1'b0;
            r_lr_slot  <= '0;
            r_aging    <= '0;
            r_found    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_pv       <= n_pv;
            r_pidx     <= n_pidx;
            r_rd_vld   <= n_rd_vld;
            r_vld      <= n_vld;
            r_thr      <= n_thr;
            r_floor    <= n_floor;
            r_time     <= n_time;
            r_lr_valid <= n_lr_valid;
            r_lr_slot  <= n_lr_slot;
            r_aging    <= n_aging;
            r_found    <= n_found;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
        r_res      <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

### rtl/psa_chk.sv
// port level checks of the scheduler, bound to the top level
module psa_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input psa_pkg::t_req i_req,
    input logic          o_done,
    input psa_pkg::t_res o_result
);
    import psa_pkg::*;

    // a load request gives its result in the next cycle
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == REQ_LOAD) |=> o_done)
        else $error("load request gave no result in the next cycle");

    // a tick request occupies the scan engine
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == REQ_TICK) |=> busy && !o_done)
        else $error("tick request did not start a scan");

    // results only appear once the block is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // grant flags need a grant
    a_grant_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.granted_valid
        |-> !o_result.preempted && !o_result.first_start && !o_result.finished)
        else $error("grant flags set without a grant");
endmodule

bind priority_scheduler_with_aging psa_chk u_psa_chk (.*);

### test/priority_scheduler_with_aging_test.sv
// self-checking testbench of the priority scheduler with aging
`timescale 1ns / 1ps

module priority_scheduler_with_aging_test;

    import psa_pkg::*;

    localparam int SLOTS      = 8;
    localparam int HALF_CLK   = 4;
    localparam int RESET_CYC  = 9;
    // a tick scan holds busy while it runs, and the strobe comes as busy falls
    localparam int SETTLE_CYC = SLOTS + 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_REQS  = 255;

    // how a directed row is checked
    localparam logic KNOWN   = 1'b1;
    localparam logic PREDICT = 1'b0;

    typedef struct packed {
        t_req       req;
        logic       known;
        t_res       res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_res                  o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [7:0]            i_cfg_data;

    priority_scheduler_with_aging #(
        .NUM_SLOTS  (SLOTS),
        .BURST_BITS (16)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // scheduler state as the testbench sees it
    logic [31:0] sch_time;
    logic [15:0] sch_work    [SLOTS];
    logic [7:0]  sch_prio    [SLOTS];
    logic [7:0]  sch_wait    [SLOTS];
    logic [31:0] sch_arrival [SLOTS];
    logic        sch_started [SLOTS];
    logic        sch_last_valid;
    logic [2:0]  sch_last_slot;
    logic [15:0] sch_aging;
    logic [7:0]  sch_threshold;
    logic [7:0]  sch_floor;

    t_res        expected_grants [$];
    t_dir_row    directed_rows   [$];
    t_res        grant_want;
    int          mismatch_count;
    int unsigned cycle_count;
    bit          gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #HALF_CLK i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // expected grant of one request, advancing the scheduler state
    task automatic predict_grant(input t_req r, output t_res res);
        int         i;
        bit         found;
        logic [2:0] best_slot;
        res = '0;
        found = 1'b0;
        best_slot = '0;
        if (r.req_type == REQ_LOAD) begin
            sch_work[r.slot]    = r.burst;
            sch_prio[r.slot]    = r.priority_req;
            sch_wait[r.slot]    = '0;
            sch_arrival[r.slot] = sch_time;
            sch_started[r.slot] = 1'b0;
            // a fresh job in the last run slot has not run yet
            if (sch_last_valid && sch_last_slot == r.slot) sch_last_valid = 1'b0;
            res.aging_events = sch_aging;
        end else begin
            // aging pass: every waiting job except the one that last ran
            for (i = 0; i < SLOTS; i++) begin
                if (sch_work[i] != 0 && !(sch_last_valid && sch_last_slot == i)) begin
                    if (sch_wait[i] != WAIT_MAX) sch_wait[i]++;
                    if (sch_wait[i] >= sch_threshold) begin
                        if (sch_prio[i] > sch_floor) sch_prio[i]--;
                        if (sch_aging != AGING_MAX) sch_aging++;
                        sch_wait[i] = '0;
                    end
                end
            end
            // selection: smallest priority value, lowest slot on a tie
            for (i = 0; i < SLOTS; i++) begin
                if (sch_work[i] != 0 && (!found || sch_prio[i] < sch_prio[best_slot])) begin
                    found = 1'b1;
                    best_slot = i[2:0];
                end
            end
            if (found) begin
                res.granted_valid = 1'b1;
                res.granted_slot  = best_slot;
                res.preempted     = sch_last_valid && sch_last_slot != best_slot;
                if (!sch_started[best_slot]) begin
                    sch_started[best_slot] = 1'b1;
                    res.first_start   = 1'b1;
                    res.response_time = sch_time - sch_arrival[best_slot];
                end
                sch_work[best_slot]--;
                if (sch_work[best_slot] == 0) begin
                    res.finished    = 1'b1;
                    res.finish_time = sch_time + 32'd1;
                end
                // a finished job stays the last run slot
                sch_last_valid = 1'b1;
                sch_last_slot  = best_slot;
            end
            res.aging_events = sch_aging;
            sch_time = sch_time + 32'd1;
        end
    endtask

    function automatic t_req tick_req();
        t_req r;
        r = '0;
        r.req_type = REQ_TICK;
        return r;
    endfunction

    function automatic t_req load_req(logic [2:0] s, logic [15:0] b, logic [7:0] p);
        t_req r;
        r.req_type     = REQ_LOAD;
        r.slot         = s;
        r.burst        = b;
        r.priority_req = p;
        return r;
    endfunction

    // append one row to the directed table
    task automatic add_row(input t_req req, input logic known, input t_res res);
        t_dir_row row;
        row.req   = req;
        row.known = known;
        row.res   = res;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(5, 40);
    endfunction

    // random request: mostly ticks, loads with small bursts so jobs finish and rotate
    function automatic t_req random_req();
        t_req        r;
        int unsigned roll;
        r.req_type     = REQ_TICK;
        r.slot         = 3'($urandom_range(0, SLOTS - 1));
        r.burst        = 16'($urandom());
        r.priority_req = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 35) begin
            r.req_type = REQ_LOAD;
            roll = $urandom_range(0, 15);
            if (roll == 1) r.burst = '0;
            else if (roll > 1) r.burst = 16'($urandom_range(1, 12));
            // crowd the low values so ties and the floor come up often
            if ($urandom_range(0, 1) == 0) r.priority_req = 8'($urandom_range(0, 7));
        end
        return r;
    endfunction

    // present one request, hold it until taken, queue what it should produce
    task automatic issue_request(input t_req r, input logic known, input t_res typed_res);
        int unsigned gap;
        t_res        pred;
        gap = pick_gap();
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req = r;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_grant(r, pred);
        expected_grants.insert(expected_grants.size(), known ? typed_res : pred);
        @(negedge i_clk);
    endtask

    // drop start and wait until every request has reported back
    task automatic settle_idle();
        start = 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_AGING_THRESHOLD) sch_threshold = data;
        else sch_floor = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] thr, input logic [7:0] flr, input bit gaps);
        settle_idle();
        write_reg(REG_AGING_THRESHOLD, thr);
        write_reg(REG_PRIORITY_FLOOR, flr);
        gaps_on = gaps;
        repeat (PHASE_REQS) issue_request(random_req(), PREDICT, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker: each strobe is compared with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result, expected none got %p", $time, o_result);
                mismatch_count++;
            end else begin
                grant_want = expected_grants.pop_front();
                check_field("granted_valid", 32'(grant_want.granted_valid),
                    32'(o_result.granted_valid));
                check_field("granted_slot", 32'(grant_want.granted_slot),
                    32'(o_result.granted_slot));
                check_field("preempted", 32'(grant_want.preempted),
                    32'(o_result.preempted));
                check_field("first_start", 32'(grant_want.first_start),
                    32'(o_result.first_start));
                check_field("response_time", grant_want.response_time,
                    o_result.response_time);
                check_field("finished", 32'(grant_want.finished),
                    32'(o_result.finished));
                check_field("finish_time", grant_want.finish_time,
                    o_result.finish_time);
                check_field("aging_events", 32'(grant_want.aging_events),
                    32'(o_result.aging_events));
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int k;
        // everything driven to a known value from time zero
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        gaps_on        = 1'b1;

        sch_time       = '0;
        sch_last_valid = 1'b0;
        sch_last_slot  = '0;
        sch_aging      = '0;
        sch_threshold  = THRESHOLD_RESET;
        sch_floor      = FLOOR_RESET;
        for (k = 0; k < SLOTS; k++) begin
            sch_work[k]    = '0;
            sch_prio[k]    = '0;
            sch_wait[k]    = '0;
            sch_arrival[k] = '0;
            sch_started[k] = 1'b0;
        end

        // directed table, run at the reset register values
        // tick with every slot empty
        add_row(tick_req(), KNOWN, t_res'('0));
        // short job into slot 0, arriving at time 1
        add_row(load_req(3'd0, 16'd2, 8'd3), KNOWN, t_res'('0));
        // first run: response time zero
        add_row(tick_req(), KNOWN,
            t_res'({1'b1, 3'd0, 1'b0, 1'b1, 32'd0, 1'b0, 32'd0, 16'd0}));
        // second run finishes at time 3
        add_row(tick_req(), KNOWN,
            t_res'({1'b1, 3'd0, 1'b0, 1'b0, 32'd0, 1'b1, 32'd3, 16'd0}));
        // largest burst at the least urgent priority in the top slot
        add_row(load_req(3'd7, 16'hFFFF, 8'd255), KNOWN, t_res'('0));
        // most urgent job
        add_row(load_req(3'd3, 16'd3, 8'd0), KNOWN, t_res'('0));
        // a finished job stays last run, so this grant reports a preemption
        add_row(tick_req(), PREDICT, t_res'('0));
        add_row(tick_req(), PREDICT, t_res'('0));
        // reload of the slot that ran last clears the last run
        add_row(load_req(3'd3, 16'd2, 8'd10), PREDICT, t_res'('0));
        add_row(tick_req(), PREDICT, t_res'('0));
        // zero burst leaves the slot empty
        add_row(load_req(3'd5, 16'd0, 8'd0), PREDICT, t_res'('0));
        add_row(load_req(3'd1, 16'd1, 8'd1), PREDICT, t_res'('0));
        // long run of ticks: aging of the big job toward the floor, finishes, preemption
        for (k = 0; k < 10; k++) add_row(tick_req(), PREDICT, t_res'('0));
        // tie at priority zero with the lower slot winning
        add_row(load_req(3'd6, 16'd1, 8'd0), PREDICT, t_res'('0));
        add_row(load_req(3'd2, 16'd1, 8'd0), PREDICT, t_res'('0));
        add_row(tick_req(), PREDICT, t_res'('0));

        // single reset at the start of the run
        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (k = 0; k < directed_rows.size(); k++)
            issue_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].res);

        // random phases over several register settings, extremes included
        run_phase(8'd1, 8'd0, 1'b1);
        // top threshold and floor: aging counted but no priority moves
        run_phase(8'd255, 8'd255, 1'b1);
        // threshold zero acts as one
        run_phase(8'd0, 8'd0, 1'b1);
        run_phase(8'd3, 8'd128, 1'b1);
        run_phase(8'($urandom_range(2, 9)), 8'($urandom_range(0, 255)), 1'b1);
        // back to back requests with no idling at all
        run_phase(8'd2, 8'd1, 1'b0);

        settle_idle();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/psa_pkg.sv
rtl/psa_ram.sv
rtl/psa_age.sv
rtl/priority_scheduler_with_aging.sv
rtl/psa_chk.sv
test/priority_scheduler_with_aging_test.sv
